FILE: sv/mts_pkg.sv
package mts_pkg;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    load_top;
    logic    capture;
    status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic one;
  } dp_sts_t;

endpackage

FILE: sv/mts_datapath.sv
module mts_datapath import mts_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1),
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic signed [31:0]  in_push_value,
  output dp_sts_t             sts,
  output logic signed [31:0]  out_top_value,
  output logic signed [31:0]  out_min_value,
  output logic [CNT_W-1:0]    out_entry_count,
  output logic                out_is_empty,
  output logic [1:0]          out_status
);

  // each word: {value, running minimum}
  logic [63:0]        mem [STACK_DEPTH];
  logic [63:0]        rd_data_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [31:0] top_val_r, top_val_nxt;
  logic signed [31:0] top_min_r, top_min_nxt;
  logic [CNT_W-1:0]   rd_ptr;

  logic signed [31:0] res_top_r, res_min_r;
  logic [CNT_W-1:0]   res_cnt_r;
  logic               res_empty_r;
  status_t            res_status_r;

  assign rd_ptr = cnt_r - CNT_W'(2);

  always_comb begin
    cnt_nxt     = cnt_r;
    top_val_nxt = top_val_r;
    top_min_nxt = top_min_r;
    if (cmd.push) begin
      cnt_nxt     = cnt_r + CNT_W'(1);
      top_val_nxt = in_push_value;
      top_min_nxt = (cnt_r != '0 && top_min_r < in_push_value) ? top_min_r : in_push_value;
    end
    if (cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cmd.load_top) begin
      top_val_nxt = rd_data_r[63:32];
      top_min_nxt = rd_data_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_min_r <= top_min_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt_r[AW-1:0]] <= {top_val_nxt, top_min_nxt};
    end
    rd_data_r <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_top_r    <= (cnt_nxt != '0) ? top_val_nxt : '0;
      res_min_r    <= (cnt_nxt != '0) ? top_min_nxt : '0;
      res_cnt_r    <= cnt_nxt;
      res_empty_r  <= (cnt_nxt == '0);
      res_status_r <= cmd.status;
    end
  end

  assign sts.full  = (cnt_r == CNT_W'(STACK_DEPTH));
  assign sts.empty = (cnt_r == '0);
  assign sts.one   = (cnt_r == CNT_W'(1));

  assign out_top_value   = res_top_r;
  assign out_min_value   = res_min_r;
  assign out_entry_count = res_cnt_r;
  assign out_is_empty    = res_empty_r;
  assign out_status      = res_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond depth");

  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 |-> top_min_r <= top_val_r)
    else $error("running minimum above top value");

endmodule

FILE: sv/mts_ctrl.sv
module mts_ctrl import mts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_action,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.status   = ST_DONE;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          if (in_action == ACT_PUSH) begin
            cmd.capture = 1'b1;
            if (sts.full) cmd.status = ST_PUSH_FULL;
            else          cmd.push   = 1'b1;
          end else if (sts.empty) begin
            cmd.capture = 1'b1;
            cmd.status  = ST_POP_EMPTY;
          end else if (sts.one) begin
            cmd.pop     = 1'b1;
            cmd.capture = 1'b1;
          end else begin
            cmd.pop   = 1'b1;
            state_nxt = S_POP_WAIT;
          end
        end
      end
      S_POP_WAIT: begin
        cmd.load_top = 1'b1;
        cmd.capture  = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.capture)              out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  a_wait_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_WAIT |-> !out_valid_r)
    else $error("pending result while pop read outstanding");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_deep_pop: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == ACT_POP && !sts.empty && !sts.one |=> state_r == S_POP_WAIT)
    else $error("pop of deep stack skipped read cycle");

endmodule

FILE: sv/min_tracking_stack.sv
// Signed 32-bit stack that also reports its minimum. Each input transaction
// pushes in_push_value (in_action = 0) or pops the top (in_action = 1), and
// yields exactly one result transaction giving the new top, the minimum, the
// entry count, an empty flag and a status (0 done, 1 pop on empty ignored,
// 2 push on full dropped). Top and minimum read 0 when empty. Every stored
// entry carries the running minimum of itself and all entries below it, so
// no rescan is ever needed. A push, a pop on empty or a pop that empties the
// stack is captured on acceptance; any other pop first passes S_POP_WAIT,
// as the new top comes from the entry RAM's registered read port. One
// transaction is in flight at a time; a new one is taken in the same cycle
// the previous result is collected. No clearing pass is needed after reset.
module min_tracking_stack import mts_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_push_value,
  // result transaction
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_top_value,
  output logic signed [31:0] out_min_value,
  output logic [CNT_W-1:0]   out_entry_count,
  output logic               out_is_empty,
  output logic [1:0]         out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: decides push / pop / ignore and owns the result handshake.
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage: top entry held in flops, full stack in RAM, result register.
  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_push_value   (in_push_value),
    .sts             (sts),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

endmodule
